// ----- design/bsrc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsrc_pkg
// Types, codes and widths shared by the barometric sensor readout sequencer.
// ----------------------------------------------------------------------------
package bsrc_pkg;

    // field widths
    localparam int REQ_W      = 2;
    localparam int RX_W       = 24;
    localparam int KIND_W     = 3;
    localparam int ADDR_W     = 7;
    localparam int CMD_W      = 8;
    localparam int LEN_W      = 2;
    localparam int WAIT_W     = 16;
    localparam int VAL_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // calibration store
    localparam int CALIB_W     = 16;
    localparam int CALIB_WORDS = 8;
    localparam int CALIB_IDX_W = $clog2(CALIB_WORDS);

    // calibration word positions used by the compensation
    localparam logic [CALIB_IDX_W-1:0] C_SENS_IDX  = CALIB_IDX_W'(1);
    localparam logic [CALIB_IDX_W-1:0] C_OFF_IDX   = CALIB_IDX_W'(2);
    localparam logic [CALIB_IDX_W-1:0] C_TCS_IDX   = CALIB_IDX_W'(3);
    localparam logic [CALIB_IDX_W-1:0] C_TCO_IDX   = CALIB_IDX_W'(4);
    localparam logic [CALIB_IDX_W-1:0] C_TREF_IDX  = CALIB_IDX_W'(5);
    localparam logic [CALIB_IDX_W-1:0] C_TSENS_IDX = CALIB_IDX_W'(6);
    localparam logic [CALIB_IDX_W-1:0] C_LAST_IDX  = CALIB_IDX_W'(CALIB_WORDS - 1);

    // request codes
    localparam logic [REQ_W-1:0] REQ_INIT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TEMP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PRES = 2'd2;
    localparam logic [REQ_W-1:0] REQ_DONE = 2'd3;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_BUS_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_LENGTH = 2'd1;
    localparam logic [ADDR_W-1:0]    BUS_ADDRESS_RST = 7'd119;
    localparam logic [WAIT_W-1:0]    WAIT_LENGTH_RST = 16'd100;

    // sensor command bytes and read lengths
    localparam logic [CMD_W-1:0] CMD_RESET  = 8'h1E;
    localparam logic [CMD_W-1:0] CMD_PROM   = 8'hA0;
    localparam logic [CMD_W-1:0] CMD_CONV_P = 8'h48;
    localparam logic [CMD_W-1:0] CMD_CONV_T = 8'h58;
    localparam logic [CMD_W-1:0] CMD_ADC    = 8'h00;
    localparam logic [LEN_W-1:0] LEN_PROM   = 2'd2;
    localparam logic [LEN_W-1:0] LEN_ADC    = 2'd3;

    // temperature offset in 0.01 degC
    localparam logic signed [VAL_W-1:0] TEMP_BASE = 32'sd2000;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE  = 3'd0,
        KIND_READ   = 3'd1,
        KIND_WAIT   = 3'd2,
        KIND_TEMP   = 3'd3,
        KIND_PRES   = 3'd4,
        KIND_DONE   = 3'd5,
        KIND_REJECT = 3'd6
    } t_kind;

    // compensation datapath steps
    typedef enum logic [3:0] {
        CALC_NONE,
        CALC_DT,
        CALC_T_MUL,
        CALC_T_FIN,
        CALC_OFF_MUL,
        CALC_SENS_MUL,
        CALC_SENS_FIN,
        CALC_PHI_MUL,
        CALC_PLO_MUL,
        CALC_ACC,
        CALC_P_FIN
    } t_calc_op;

    // controller to datapath
    typedef struct packed {
        t_calc_op               calc;
        logic                   calib_wr;
        logic [CALIB_IDX_W-1:0] calib_idx;
        logic                   raw_wr;
        logic                   out_load;
        t_kind                  kind;
        logic [CMD_W-1:0]       cmd_byte;
        logic [LEN_W-1:0]       read_len;
    } t_dp_cmd;

endpackage
`default_nettype wire

// ----- design/bsrc_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsrc interfaces
// Event, response and register-write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bsrc_req_if
    import bsrc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [RX_W-1:0]  rx_data;

    modport source (output valid, output req_type, output rx_data, input ready);
    modport sink   (input valid, input req_type, input rx_data, output ready);
endinterface

interface bsrc_rsp_if
    import bsrc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic [ADDR_W-1:0]       dev_address;
    logic [CMD_W-1:0]        cmd_byte;
    logic [LEN_W-1:0]        read_len;
    logic [WAIT_W-1:0]       wait_ms;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output kind, output dev_address, output cmd_byte,
                    output read_len, output wait_ms, output value, input ready);
    modport sink   (input valid, input kind, input dev_address, input cmd_byte,
                    input read_len, input wait_ms, input value, output ready);
endinterface

interface bsrc_cfg_if
    import bsrc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- design/bsrc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsrc_ctrl
// Sensor sequencer phase, compensation step sequencing and output handshake.
// ----------------------------------------------------------------------------
module bsrc_ctrl
    import bsrc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [REQ_W-1:0] i_req_type,
    output logic                  o_in_ready,
    input  wire logic             i_out_ready,
    output logic                  o_out_valid,
    output t_dp_cmd               o_cmd
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RESET_SENT,
        PH_PROM_CMD_SENT,
        PH_PROM_READ_SENT,
        PH_P_CONV_SENT,
        PH_P_WAITING,
        PH_P_ADC_SENT,
        PH_P_READ_SENT,
        PH_T_CONV_SENT,
        PH_T_WAITING,
        PH_T_ADC_SENT,
        PH_T_READ_SENT
    } t_phase;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_TEMP,
        OP_PRES,
        OP_INIT
    } t_oper;

    typedef enum logic [3:0] {
        CS_IDLE,
        CS_T_MUL,
        CS_T_FIN,
        CS_OFF_MUL,
        CS_SENS_MUL,
        CS_SENS_FIN,
        CS_PHI_MUL,
        CS_PLO_MUL,
        CS_ACC,
        CS_P_FIN,
        CS_EMIT
    } t_ctl_state;

    t_ctl_state             r_state, n_state;
    t_phase                 r_phase, n_phase;
    t_oper                  r_oper, n_oper;
    logic [CALIB_IDX_W-1:0] r_calib_idx, n_calib_idx;
    t_kind                  r_kind, n_kind;
    logic [CMD_W-1:0]       r_cmd_byte, n_cmd_byte;
    logic [LEN_W-1:0]       r_read_len, n_read_len;
    logic                   r_out_valid, n_out_valid;
    logic                   in_acc;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= CS_IDLE;
            r_phase     <= PH_IDLE;
            r_oper      <= OP_NONE;
            r_calib_idx <= '0;
            r_kind      <= KIND_REJECT;
            r_cmd_byte  <= '0;
            r_read_len  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_oper      <= n_oper;
            r_calib_idx <= n_calib_idx;
            r_kind      <= n_kind;
            r_cmd_byte  <= n_cmd_byte;
            r_read_len  <= n_read_len;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_oper      = r_oper;
        n_calib_idx = r_calib_idx;
        n_kind      = r_kind;
        n_cmd_byte  = r_cmd_byte;
        n_read_len  = r_read_len;
        o_cmd           = '0;
        o_cmd.calc      = CALC_NONE;
        o_cmd.kind      = r_kind;
        o_cmd.cmd_byte  = r_cmd_byte;
        o_cmd.read_len  = r_read_len;
        o_cmd.calib_idx = r_calib_idx;
        o_in_ready  = (r_state == CS_IDLE);
        in_acc      = i_in_valid && o_in_ready;

        case (r_state)
            CS_IDLE: begin
                if (in_acc) begin
                    // default answer: a bare response word with no payload
                    n_state    = CS_EMIT;
                    n_kind     = KIND_REJECT;
                    n_cmd_byte = '0;
                    n_read_len = '0;
                    if (i_req_type != REQ_DONE) begin
                        if (r_phase == PH_IDLE) begin
                            n_kind = KIND_WRITE;
                            case (i_req_type)
                                REQ_INIT: begin
                                    n_oper      = OP_INIT;
                                    n_calib_idx = '0;
                                    n_phase     = PH_RESET_SENT;
                                    n_cmd_byte  = CMD_RESET;
                                end
                                REQ_TEMP: begin
                                    n_oper     = OP_TEMP;
                                    n_phase    = PH_T_CONV_SENT;
                                    n_cmd_byte = CMD_CONV_T;
                                end
                                default: begin
                                    n_oper     = OP_PRES;
                                    n_phase    = PH_P_CONV_SENT;
                                    n_cmd_byte = CMD_CONV_P;
                                end
                            endcase
                        end
                    end else begin
                        case (r_phase)
                            PH_RESET_SENT: begin
                                n_phase    = PH_PROM_CMD_SENT;
                                n_kind     = KIND_WRITE;
                                n_cmd_byte = CMD_PROM | CMD_W'({r_calib_idx, 1'b0});
                            end
                            PH_PROM_CMD_SENT: begin
                                n_phase    = PH_PROM_READ_SENT;
                                n_kind     = KIND_READ;
                                n_read_len = LEN_PROM;
                            end
                            PH_PROM_READ_SENT: begin
                                o_cmd.calib_wr = 1'b1;
                                if (r_calib_idx != C_LAST_IDX) begin
                                    n_calib_idx = r_calib_idx + 1'b1;
                                    n_phase     = PH_PROM_CMD_SENT;
                                    n_kind      = KIND_WRITE;
                                    n_cmd_byte  = CMD_PROM | CMD_W'({n_calib_idx, 1'b0});
                                end else begin
                                    n_calib_idx = '0;
                                    n_phase     = PH_IDLE;
                                    n_oper      = OP_NONE;
                                    n_kind      = KIND_DONE;
                                end
                            end
                            PH_P_CONV_SENT: begin
                                n_phase = PH_P_WAITING;
                                n_kind  = KIND_WAIT;
                            end
                            PH_T_CONV_SENT: begin
                                n_phase = PH_T_WAITING;
                                n_kind  = KIND_WAIT;
                            end
                            PH_P_WAITING: begin
                                n_phase    = PH_P_ADC_SENT;
                                n_kind     = KIND_WRITE;
                                n_cmd_byte = CMD_ADC;
                            end
                            PH_T_WAITING: begin
                                n_phase    = PH_T_ADC_SENT;
                                n_kind     = KIND_WRITE;
                                n_cmd_byte = CMD_ADC;
                            end
                            PH_P_ADC_SENT: begin
                                n_phase    = PH_P_READ_SENT;
                                n_kind     = KIND_READ;
                                n_read_len = LEN_ADC;
                            end
                            PH_T_ADC_SENT: begin
                                n_phase    = PH_T_READ_SENT;
                                n_kind     = KIND_READ;
                                n_read_len = LEN_ADC;
                            end
                            PH_P_READ_SENT: begin
                                o_cmd.raw_wr = 1'b1;
                                n_phase      = PH_T_CONV_SENT;
                                n_kind       = KIND_WRITE;
                                n_cmd_byte   = CMD_CONV_T;
                            end
                            PH_T_READ_SENT: begin
                                // temperature difference first, then the multiply chain
                                o_cmd.calc = CALC_DT;
                                n_phase    = PH_IDLE;
                                n_oper     = OP_NONE;
                                if (r_oper == OP_PRES) begin
                                    n_kind  = KIND_PRES;
                                    n_state = CS_OFF_MUL;
                                end else begin
                                    n_kind  = KIND_TEMP;
                                    n_state = CS_T_MUL;
                                end
                            end
                            default: begin
                                n_kind = KIND_REJECT;
                            end
                        endcase
                    end
                end
            end
            CS_T_MUL: begin
                o_cmd.calc = CALC_T_MUL;
                n_state    = CS_T_FIN;
            end
            CS_T_FIN: begin
                o_cmd.calc = CALC_T_FIN;
                n_state    = CS_EMIT;
            end
            CS_OFF_MUL: begin
                o_cmd.calc = CALC_OFF_MUL;
                n_state    = CS_SENS_MUL;
            end
            CS_SENS_MUL: begin
                o_cmd.calc = CALC_SENS_MUL;
                n_state    = CS_SENS_FIN;
            end
            CS_SENS_FIN: begin
                o_cmd.calc = CALC_SENS_FIN;
                n_state    = CS_PHI_MUL;
            end
            CS_PHI_MUL: begin
                o_cmd.calc = CALC_PHI_MUL;
                n_state    = CS_PLO_MUL;
            end
            CS_PLO_MUL: begin
                o_cmd.calc = CALC_PLO_MUL;
                n_state    = CS_ACC;
            end
            CS_ACC: begin
                o_cmd.calc = CALC_ACC;
                n_state    = CS_P_FIN;
            end
            CS_P_FIN: begin
                o_cmd.calc = CALC_P_FIN;
                n_state    = CS_EMIT;
            end
            CS_EMIT: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = CS_IDLE;
                end
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase

        n_out_valid = o_cmd.out_load || (r_out_valid && !i_out_ready);
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    // an output word is never overwritten while it still waits
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output word overwritten");

    // the sequencer holds an operation exactly while it is away from idle
    a_oper_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) == (r_oper == OP_NONE))
        else $error("operation and phase disagree");

    // calibration index only moves during the calibration read loop
    a_idx_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_calib_idx != '0) |-> (r_phase == PH_PROM_CMD_SENT || r_phase == PH_PROM_READ_SENT))
        else $error("calibration index outside init");

    // final ADC completion starts a compensation run
    a_calc_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req_type == REQ_DONE && r_phase == PH_T_READ_SENT)
        |=> (r_state == CS_T_MUL || r_state == CS_OFF_MUL))
        else $error("compensation not started");
`endif

endmodule
`default_nettype wire

// ----- design/bsrc_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsrc_dp
// Register file, calibration store, compensation arithmetic and output word.
// ----------------------------------------------------------------------------
module bsrc_dp
    import bsrc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    input  wire logic [RX_W-1:0]       i_rx_data,
    input  wire logic                  i_cfg_wr,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [KIND_W-1:0]          o_kind,
    output logic [ADDR_W-1:0]          o_dev_address,
    output logic [CMD_W-1:0]           o_cmd_byte,
    output logic [LEN_W-1:0]           o_read_len,
    output logic [WAIT_W-1:0]          o_wait_ms,
    output logic signed [VAL_W-1:0]    o_value
);

    localparam int DT_W   = 25;
    localparam int MA_W   = 26;
    localparam int MB_W   = 22;
    localparam int PROD_W = MA_W + MB_W;
    localparam int OFF_W  = 36;
    localparam int SENS_W = 35;
    localparam int SPLIT  = 21;

    logic [ADDR_W-1:0]         r_bus_address;
    logic [WAIT_W-1:0]         r_wait_length;
    logic [CALIB_W-1:0]        r_calib [CALIB_WORDS];
    logic [RX_W-1:0]           r_raw;
    logic signed [DT_W-1:0]    r_dt;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [OFF_W-1:0]   r_off;
    logic signed [SENS_W-1:0]  r_sens;
    logic signed [PROD_W-1:0]  r_acc;
    logic signed [VAL_W-1:0]   r_val;
    logic [KIND_W-1:0]         r_kind;
    logic [ADDR_W-1:0]         r_dev_address;
    logic [CMD_W-1:0]          r_cmd_byte;
    logic [LEN_W-1:0]          r_read_len;
    logic [WAIT_W-1:0]         r_wait_ms;
    logic signed [VAL_W-1:0]   r_value;

    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [MA_W-1:0]    dt_ext;
    logic signed [MA_W-1:0]    d1_ext;
    logic signed [PROD_W-1:0]  p_diff;
    logic                      prod_en;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_address <= BUS_ADDRESS_RST;
            r_wait_length <= WAIT_LENGTH_RST;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                CFG_BUS_ADDRESS: r_bus_address <= i_cfg_data[ADDR_W-1:0];
                CFG_WAIT_LENGTH: r_wait_length <= i_cfg_data[WAIT_W-1:0];
                default: ;
            endcase
        end
    end

    // calibration words and raw pressure sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CALIB_WORDS; i++) begin
                r_calib[i] <= '0;
            end
            r_raw <= '0;
        end else begin
            if (i_cmd.calib_wr) begin
                r_calib[i_cmd.calib_idx] <= i_rx_data[CALIB_W-1:0];
            end
            if (i_cmd.raw_wr) begin
                r_raw <= i_rx_data;
            end
        end
    end

    // shared multiplier operand selection
    assign dt_ext = MA_W'(r_dt);
    assign d1_ext = $signed({{(MA_W-RX_W){1'b0}}, r_raw});

    always_comb begin
        mul_a = dt_ext;
        mul_b = '0;
        case (i_cmd.calc)
            CALC_T_MUL:    mul_b = $signed({{(MB_W-CALIB_W){1'b0}}, r_calib[C_TSENS_IDX]});
            CALC_OFF_MUL:  mul_b = $signed({{(MB_W-CALIB_W){1'b0}}, r_calib[C_TCO_IDX]});
            CALC_SENS_MUL: mul_b = $signed({{(MB_W-CALIB_W){1'b0}}, r_calib[C_TCS_IDX]});
            CALC_PHI_MUL: begin
                mul_a = d1_ext;
                mul_b = MB_W'($signed(r_sens[SENS_W-1:SPLIT]));
            end
            CALC_PLO_MUL: begin
                mul_a = d1_ext;
                mul_b = $signed({1'b0, r_sens[SPLIT-1:0]});
            end
            default: ;
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign prod_en = (i_cmd.calc inside {CALC_T_MUL, CALC_OFF_MUL, CALC_SENS_MUL,
                                         CALC_PHI_MUL, CALC_PLO_MUL});
    assign p_diff  = r_acc - PROD_W'(r_off);

    // compensation steps
    always_ff @(posedge i_clk) begin
        if (prod_en) begin
            r_prod <= mul_p;
        end
        case (i_cmd.calc)
            CALC_DT: r_dt <= $signed({1'b0, i_rx_data})
                            - $signed({1'b0, r_calib[C_TREF_IDX], 8'h00});
            CALC_T_FIN: r_val <= TEMP_BASE + VAL_W'($signed(r_prod[PROD_W-1:23]));
            CALC_SENS_MUL: r_off <= $signed({4'b0, r_calib[C_OFF_IDX], 16'h0000})
                                  + r_prod[OFF_W+6:7];
            CALC_SENS_FIN: r_sens <= $signed({4'b0, r_calib[C_SENS_IDX], 15'h0000})
                                   + r_prod[SENS_W+7:8];
            CALC_PLO_MUL: r_acc <= r_prod;
            // low partial product is non-negative, so its floor is a plain shift
            CALC_ACC: r_acc <= r_acc + $signed({{SPLIT{1'b0}}, r_prod[PROD_W-1:SPLIT]});
            CALC_P_FIN: r_val <= p_diff[VAL_W+14:15];
            default: ;
        endcase
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_kind        <= i_cmd.kind;
            r_dev_address <= (i_cmd.kind inside {KIND_WRITE, KIND_READ}) ? r_bus_address : '0;
            r_cmd_byte    <= (i_cmd.kind == KIND_WRITE) ? i_cmd.cmd_byte : '0;
            r_read_len    <= (i_cmd.kind == KIND_READ) ? i_cmd.read_len : '0;
            r_wait_ms     <= (i_cmd.kind == KIND_WAIT) ? r_wait_length : '0;
            r_value       <= (i_cmd.kind inside {KIND_TEMP, KIND_PRES}) ? r_val : '0;
        end
    end

    assign o_kind        = r_kind;
    assign o_dev_address = r_dev_address;
    assign o_cmd_byte    = r_cmd_byte;
    assign o_read_len    = r_read_len;
    assign o_wait_ms     = r_wait_ms;
    assign o_value       = r_value;

endmodule
`default_nettype wire

// ----- design/baro_sensor_readout_compensation.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// baro_sensor_readout_compensation
// Barometric sensor command sequencer with first-order compensation.
// ----------------------------------------------------------------------------
// Every event word on i_req (init, temperature, pressure, or completion of
// the previous bus operation) yields exactly one response word on o_rsp: a
// bus write, a bus read, a wait, a temperature or pressure result in 0.01
// units, init done, or rejected. A plain command event goes straight to the
// emit state, which loads the response register once o_rsp is free. The
// completion ending a temperature read first steps through T_MUL and T_FIN,
// and one ending a pressure read through OFF_MUL, SENS_MUL, SENS_FIN,
// PHI_MUL, PLO_MUL, ACC and P_FIN, via the single 26 x 22 bit multiplier.
// A new event is accepted while an earlier response still waits on o_rsp.
// Register writes on i_cfg are always accepted and should be made while no
// event is in progress. Calibration words are zero after reset.
// ----------------------------------------------------------------------------
module baro_sensor_readout_compensation
    import bsrc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bsrc_req_if.sink   i_req,
    bsrc_rsp_if.source o_rsp,
    bsrc_cfg_if.sink   i_cfg
);

    t_dp_cmd dp_cmd;
    logic    in_ready;
    logic    out_valid;

    // sequencer and step control
    bsrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_req_type  (i_req.req_type),
        .o_in_ready  (in_ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (out_valid),
        .o_cmd       (dp_cmd)
    );

    // registers, calibration store and arithmetic
    bsrc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_rx_data     (i_req.rx_data),
        .i_cfg_wr      (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .o_kind        (o_rsp.kind),
        .o_dev_address (o_rsp.dev_address),
        .o_cmd_byte    (o_rsp.cmd_byte),
        .o_read_len    (o_rsp.read_len),
        .o_wait_ms     (o_rsp.wait_ms),
        .o_value       (o_rsp.value)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;
    assign i_cfg.ready = 1'b1;

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the barometric sensor readout sequencer. It drives
// event words with random gaps and back-pressures the response channel, and
// runs a cycle-free model of the sequencer and its compensation maths. Every
// response word is checked field by field, in order, against that model.
// ----------------------------------------------------------------------------
module tb;
    import bsrc_pkg::*;

    localparam int STALL_LIMIT = 2000;  // cycles with no handshake at all
    localparam int PRINT_LIMIT = 50;    // mismatch lines printed before going quiet
    localparam int PHASE_WORDS = 305;   // random event words per register setting

    // sequencer phases, as the block walks a bus transaction
    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_RESET_SENT,
        SQ_PROM_CMD,
        SQ_PROM_READ,
        SQ_P_CONV,
        SQ_P_WAIT,
        SQ_P_ADC,
        SQ_P_READ,
        SQ_T_CONV,
        SQ_T_WAIT,
        SQ_T_ADC,
        SQ_T_READ
    } t_seq_phase;

    typedef enum logic [1:0] {
        OPN_NONE,
        OPN_TEMP,
        OPN_PRES,
        OPN_INIT
    } t_seq_op;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] addr;
        logic [CMD_W-1:0]  cmd;
        logic [LEN_W-1:0]  len;
        logic [WAIT_W-1:0] wait_ms;
        logic [VAL_W-1:0]  value;
    } t_response;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bsrc_req_if req_if ();
    bsrc_rsp_if rsp_if ();
    bsrc_cfg_if cfg_if ();

    baro_sensor_readout_compensation dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // predicted sequencer state
    logic [ADDR_W-1:0]  bus_addr   = BUS_ADDRESS_RST;
    logic [WAIT_W-1:0]  wait_len   = WAIT_LENGTH_RST;
    t_seq_phase         seq_phase  = SQ_IDLE;
    t_seq_op            seq_op     = OPN_NONE;
    logic [CALIB_W-1:0] calib_store [CALIB_WORDS] = '{default: '0};
    logic [CALIB_IDX_W-1:0] calib_ptr = '0;
    logic [RX_W-1:0]    raw_pres   = '0;

    t_response pending_rsp_q [$];
    t_response head_rsp;

    bit idle_on = 1'b1;
    int mismatch_count = 0;
    int words_sent     = 0;
    int regs_written   = 0;
    int n_temp = 0, n_pres = 0, n_done = 0, n_reject = 0, n_bus = 0;

    // clock, 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic t_response build_response(t_kind k, logic [CMD_W-1:0] cmd,
                                                 logic [LEN_W-1:0] len,
                                                 logic [WAIT_W-1:0] wt,
                                                 logic [VAL_W-1:0] val);
        t_response r;
        r.kind    = k;
        r.addr    = (k == KIND_WRITE || k == KIND_READ) ? bus_addr : '0;
        r.cmd     = (k == KIND_WRITE) ? cmd : '0;
        r.len     = (k == KIND_READ) ? len : '0;
        r.wait_ms = (k == KIND_WAIT) ? wt : '0;
        r.value   = (k == KIND_TEMP || k == KIND_PRES) ? val : '0;
        return r;
    endfunction

    // ADC temperature minus reference, as a wide signed number
    function automatic longint temp_delta(logic [RX_W-1:0] d2);
        return longint'(d2) - (longint'(calib_store[C_TREF_IDX]) <<< 8);
    endfunction

    function automatic logic [VAL_W-1:0] comp_temperature(logic [RX_W-1:0] d2);
        longint t;
        t = longint'(TEMP_BASE)
          + ((temp_delta(d2) * longint'(calib_store[C_TSENS_IDX])) >>> 23);
        return t[VAL_W-1:0];
    endfunction

    // first-order pressure; >>> on signed longint floors, result kept to 32 bits
    function automatic logic [VAL_W-1:0] comp_pressure(logic [RX_W-1:0] d1,
                                                       logic [RX_W-1:0] d2);
        longint dt, off, sens, p;
        dt   = temp_delta(d2);
        off  = (longint'(calib_store[C_OFF_IDX]) <<< 16)
             + ((longint'(calib_store[C_TCO_IDX]) * dt) >>> 7);
        sens = (longint'(calib_store[C_SENS_IDX]) <<< 15)
             + ((longint'(calib_store[C_TCS_IDX]) * dt) >>> 8);
        p    = (((longint'(d1) * sens) >>> 21) - off) >>> 15;
        return p[VAL_W-1:0];
    endfunction

    // one event word in, the one response it causes out
    function automatic t_response sequencer_step(logic [REQ_W-1:0] req,
                                                 logic [RX_W-1:0] rx);
        t_response r;
        if (req != REQ_DONE) begin
            if (seq_phase != SQ_IDLE)
                return build_response(KIND_REJECT, '0, '0, '0, '0);
            case (req)
                REQ_INIT: begin
                    seq_op    = OPN_INIT;
                    calib_ptr = '0;
                    seq_phase = SQ_RESET_SENT;
                    r = build_response(KIND_WRITE, CMD_RESET, '0, '0, '0);
                end
                REQ_TEMP: begin
                    seq_op    = OPN_TEMP;
                    seq_phase = SQ_T_CONV;
                    r = build_response(KIND_WRITE, CMD_CONV_T, '0, '0, '0);
                end
                default: begin
                    seq_op    = OPN_PRES;
                    seq_phase = SQ_P_CONV;
                    r = build_response(KIND_WRITE, CMD_CONV_P, '0, '0, '0);
                end
            endcase
            return r;
        end
        case (seq_phase)
            SQ_RESET_SENT: begin
                seq_phase = SQ_PROM_CMD;
                r = build_response(KIND_WRITE, CMD_PROM | {calib_ptr, 1'b0}, '0, '0, '0);
            end
            SQ_PROM_CMD: begin
                seq_phase = SQ_PROM_READ;
                r = build_response(KIND_READ, '0, LEN_PROM, '0, '0);
            end
            SQ_PROM_READ: begin
                calib_store[calib_ptr] = rx[CALIB_W-1:0];
                if (calib_ptr != C_LAST_IDX) begin
                    calib_ptr = calib_ptr + 1'b1;
                    seq_phase = SQ_PROM_CMD;
                    r = build_response(KIND_WRITE, CMD_PROM | {calib_ptr, 1'b0},
                                       '0, '0, '0);
                end else begin
                    calib_ptr = '0;
                    seq_phase = SQ_IDLE;
                    seq_op    = OPN_NONE;
                    r = build_response(KIND_DONE, '0, '0, '0, '0);
                end
            end
            SQ_P_CONV: begin
                seq_phase = SQ_P_WAIT;
                r = build_response(KIND_WAIT, '0, '0, wait_len, '0);
            end
            SQ_T_CONV: begin
                seq_phase = SQ_T_WAIT;
                r = build_response(KIND_WAIT, '0, '0, wait_len, '0);
            end
            SQ_P_WAIT: begin
                seq_phase = SQ_P_ADC;
                r = build_response(KIND_WRITE, CMD_ADC, '0, '0, '0);
            end
            SQ_T_WAIT: begin
                seq_phase = SQ_T_ADC;
                r = build_response(KIND_WRITE, CMD_ADC, '0, '0, '0);
            end
            SQ_P_ADC: begin
                seq_phase = SQ_P_READ;
                r = build_response(KIND_READ, '0, LEN_ADC, '0, '0);
            end
            SQ_T_ADC: begin
                seq_phase = SQ_T_READ;
                r = build_response(KIND_READ, '0, LEN_ADC, '0, '0);
            end
            SQ_P_READ: begin
                raw_pres  = rx;
                seq_phase = SQ_T_CONV;
                r = build_response(KIND_WRITE, CMD_CONV_T, '0, '0, '0);
            end
            SQ_T_READ: begin
                if (seq_op == OPN_PRES)
                    r = build_response(KIND_PRES, '0, '0, '0, comp_pressure(raw_pres, rx));
                else
                    r = build_response(KIND_TEMP, '0, '0, '0, comp_temperature(rx));
                seq_phase = SQ_IDLE;
                seq_op    = OPN_NONE;
            end
            // completion with nothing in progress
            default: r = build_response(KIND_REJECT, '0, '0, '0, '0);
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    // one event word, with an occasional gap in front of it
    task automatic send_event(logic [REQ_W-1:0] req, logic [RX_W-1:0] rx);
        t_response r;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= req;
        req_if.rx_data  <= rx;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        r = sequencer_step(req, rx);
        pending_rsp_q.push_back(r);
        words_sent++;
    endtask

    // drop valid and let every pending response come back
    task automatic wait_drained();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        if (idx == CFG_BUS_ADDRESS)
            bus_addr = data[ADDR_W-1:0];
        else if (idx == CFG_WAIT_LENGTH)
            wait_len = data;
        regs_written++;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // received bytes: mostly random, sometimes all zero or all ones
    function automatic logic [RX_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return RX_W'($urandom);
        endcase
    endfunction

    // complete whatever transaction is open so the block ends up idle
    task automatic finish_sequence();
        while (seq_phase != SQ_IDLE) send_event(REQ_DONE, pick_sample());
    endtask

    // request code other than completion, picked at random
    function automatic logic [REQ_W-1:0] REQ_WIDTH_REQ();
        case ($urandom_range(0, 2))
            0:       return REQ_INIT;
            1:       return REQ_TEMP;
            default: return REQ_PRES;
        endcase
    endfunction

    // mostly well-formed transactions, salted with stray requests and completions
    task automatic run_traffic(int n_words);
        int k;
        for (k = 0; k < n_words; k++) begin
            if (seq_phase == SQ_IDLE) begin
                case ($urandom_range(0, 19))
                    0:          send_event(REQ_DONE, pick_sample());
                    1, 2:       send_event(REQ_INIT, pick_sample());
                    3, 4, 5, 6, 7, 8, 9, 10:
                                send_event(REQ_TEMP, pick_sample());
                    default:    send_event(REQ_PRES, pick_sample());
                endcase
            end else if ($urandom_range(0, 15) == 0) begin
                send_event(REQ_WIDTH_REQ(), pick_sample());
            end else begin
                send_event(REQ_DONE, pick_sample());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // stray completion, then a full pressure read on the zero calibration
    task automatic test_pressure_uncalibrated();
        send_event(REQ_DONE, '1);
        send_event(REQ_PRES, '0);
        send_event(REQ_TEMP, 24'h5A5A5A);  // busy, must be rejected
        repeat (3) send_event(REQ_DONE, pick_sample());
        send_event(REQ_DONE, '1);          // full-scale raw pressure
        repeat (3) send_event(REQ_DONE, '0);
        send_event(REQ_DONE, 24'h123456);
    endtask

    // load calibration words at their extremes, with junk in the top byte
    task automatic test_calibration_load();
        logic [CALIB_W-1:0] words [CALIB_WORDS] = '{16'h0000, 16'hFFFF, 16'hFFFF,
                                                    16'hFFFF, 16'hFFFF, 16'h8000,
                                                    16'hFFFF, 16'h5A5A};
        int i;
        send_event(REQ_INIT, '0);
        send_event(REQ_DONE, '0);
        for (i = 0; i < CALIB_WORDS; i++) begin
            send_event(REQ_DONE, pick_sample());
            if (i == 3)
                send_event(REQ_INIT, '1);  // init while init runs
            send_event(REQ_DONE, {8'($urandom), words[i]});
        end
    endtask

    // temperature with address 0 and the wait length changed mid-transaction
    task automatic test_temperature_wait_change();
        wait_drained();
        write_register(CFG_BUS_ADDRESS, '0);
        send_event(REQ_TEMP, '1);
        wait_drained();
        write_register(CFG_WAIT_LENGTH, '0);
        send_event(REQ_DONE, pick_sample());
        send_event(REQ_DONE, pick_sample());
        send_event(REQ_DONE, pick_sample());
        send_event(REQ_DONE, '0);          // lowest ADC count, negative delta
    endtask

    // random traffic under a series of register settings
    task automatic test_traffic_under_settings();
        int s;
        for (s = 0; s < 6; s++) begin
            wait_drained();
            case (s)
                0: begin
                    write_register(CFG_BUS_ADDRESS, CFG_DATA_W'(BUS_ADDRESS_RST));
                    write_register(CFG_WAIT_LENGTH, WAIT_LENGTH_RST);
                end
                1: begin
                    write_register(CFG_BUS_ADDRESS, 16'd127);
                    write_register(CFG_WAIT_LENGTH, 16'hFFFF);
                end
                2: begin
                    write_register(CFG_BUS_ADDRESS, 16'd0);
                    write_register(CFG_WAIT_LENGTH, 16'd1);
                end
                default: begin
                    write_register(CFG_BUS_ADDRESS, CFG_DATA_W'($urandom));
                    write_register(CFG_WAIT_LENGTH, CFG_DATA_W'($urandom));
                end
            endcase
            if (s == 5)
                idle_on = 1'b0;
            run_traffic(PHASE_WORDS);
            finish_sequence();
        end
    endtask

    // ------------------------------------------------------------------------
    // response checking
    // ------------------------------------------------------------------------
    task automatic flag_error(string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_rsp_q.size() == 0) begin
                flag_error("response word with nothing pending");
            end else begin
                head_rsp = pending_rsp_q.pop_front();
                check_field("kind", rsp_if.kind, head_rsp.kind);
                check_field("dev_address", rsp_if.dev_address, head_rsp.addr);
                check_field("cmd_byte", rsp_if.cmd_byte, head_rsp.cmd);
                check_field("read_len", rsp_if.read_len, head_rsp.len);
                check_field("wait_ms", rsp_if.wait_ms, head_rsp.wait_ms);
                check_field("value", rsp_if.value, head_rsp.value);
            end
            case (rsp_if.kind)
                KIND_TEMP:   n_temp++;
                KIND_PRES:   n_pres++;
                KIND_DONE:   n_done++;
                KIND_REJECT: n_reject++;
                default:     n_bus++;
            endcase
        end
    end

    // response back-pressure in bursts
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
            end
            rsp_if.ready <= 1'b1;
        end
    end

    // watchdog: too long without any handshake means the block has hung
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        req_if.valid    = 1'b0;
        req_if.req_type = REQ_DONE;
        req_if.rx_data  = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = CFG_BUS_ADDRESS;
        cfg_if.data     = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_pressure_uncalibrated();
        test_calibration_load();
        test_temperature_wait_change();
        test_traffic_under_settings();

        wait_drained();
        repeat (12) @(posedge i_clk);

        $display("%0d event words, %0d register writes; responses: %0d bus/wait, %0d temperature,",
                 words_sent, regs_written, n_bus, n_temp);
        $display("%0d pressure, %0d init done, %0d rejected; %0d mismatches",
                 n_pres, n_done, n_reject, mismatch_count);
        if (mismatch_count == 0 && pending_rsp_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
